### sv/utf8d_pkg.sv
package utf8d_pkg;

  localparam int unsigned CpW   = 21;
  localparam int unsigned OffW  = 16;
  localparam int unsigned LenW  = 3;
  localparam int unsigned OutDataW = 48;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_BAD_LEAD   = 2'd1,
    STATUS_BAD_FOLLOW = 2'd2,
    STATUS_TRUNC      = 2'd3
  } status_t;

  // Decoder sequence state
  typedef struct packed {
    logic [1:0]      rem;      // continuation bytes still expected
    logic [LenW-1:0] seq_len;  // length of the open sequence
    logic [CpW-1:0]  acc;      // code point bits gathered so far
    logic [OffW-1:0] start;    // offset of the open sequence's lead byte
    logic [OffW-1:0] offset;   // offset of the next byte
    logic            pend;     // bad continuation seen in this sequence
    logic            disc;     // dropping bytes up to the end mark
  } state_t;

  typedef struct packed {
    logic [CpW-1:0]  code_point;
    status_t         status;
    logic [OffW-1:0] error_position;
    logic [LenW-1:0] error_length;
    logic            last_result;
  } result_t;

endpackage

### sv/utf8_to_code_point_decoder.sv
// UTF-8 to code point decoder. Feed one byte of the string per transfer on
// in_tdata, with in_tlast on the last byte; each completed code point (one
// to four bytes) comes out as one transfer with status OK. A stray
// continuation byte or a lead byte with five or more leading ones is an
// invalid-lead error of length 1; a malformed continuation byte is reported
// as a bad-continuation error with the sequence length once the sequence
// would have completed; a string that ends inside a sequence is a truncation
// error of length 1. Any error is the last result of its string and the
// remaining bytes up to in_tlast are dropped silently. Overlong forms and
// surrogates are not checked. error_position is the byte offset of the
// failing sequence's lead byte and wraps at MAX_STRING_BYTES (or 65536).
// Throughput is one byte per clock while the result register can take a
// result: an input register feeds a single pass of decode logic that
// updates the sequence state and loads the result register, and a byte is
// held in the input register while the result register is full and
// out_tready is low. Bytes that produce no result still pass the decode stage.
module utf8_to_code_point_decoder #(
  parameter int unsigned MAX_STRING_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_in
  input  logic        in_tlast,   // end_of_string
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [20:0] code_point, [22:21] status,
                                  // [38:23] error_position,
                                  // [41:39] error_length, [47:42] zero
  output logic        out_tlast   // last_result
);

  // input register
  logic       ib_valid_r;
  logic [7:0] ib_byte_r;
  logic       ib_eos_r;

  logic               ob_space;
  logic               step_go;
  logic               res_valid;
  utf8d_pkg::result_t res;

  // advance the decode stage only when the result register can take a result
  assign step_go   = ib_valid_r && ob_space;
  assign in_tready = !ib_valid_r || step_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ib_valid_r <= 1'b0;
    end else if (in_tready) begin
      ib_valid_r <= in_tvalid;
    end
  end

  // hold the byte until the decode stage consumes it
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      ib_byte_r <= in_tdata;
      ib_eos_r  <= in_tlast;
    end
  end

  utf8d_core #(
    .MaxStringBytes (MAX_STRING_BYTES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_go   (step_go),
    .byte_in   (ib_byte_r),
    .eos       (ib_eos_r),
    .res_valid (res_valid),
    .res       (res)
  );

  utf8d_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step_go && res_valid),
    .res        (res),
    .space      (ob_space),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

### sv/utf8d_core.sv
module utf8d_core #(
  parameter int unsigned MaxStringBytes = 65536
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_go,
  input  logic [7:0]         byte_in,
  input  logic               eos,
  output logic               res_valid,
  output utf8d_pkg::result_t res
);

  // Offset wraps on reaching the string limit, or on 16-bit overflow
  localparam logic [16:0] WrapLim = (MaxStringBytes < 65536) ?
                                    17'(MaxStringBytes) : 17'h10000;

  utf8d_pkg::state_t st_r, st_nxt;

  logic [utf8d_pkg::OffW-1:0] off_inc, off_adv;
  logic [2:0]                 ones;
  logic [utf8d_pkg::CpW-1:0]  lead_bits, acc_shift;
  logic [1:0]                 rem_dec;
  logic                       bad;
  logic                       em;
  utf8d_pkg::status_t         em_status;
  logic [utf8d_pkg::CpW-1:0]  em_cp;
  logic [utf8d_pkg::OffW-1:0] em_pos;
  logic [utf8d_pkg::LenW-1:0] em_len;
  logic                       em_err;

  assign off_inc = st_r.offset + 16'd1;
  assign off_adv = ({1'b0, off_inc} >= WrapLim) ? '0 : off_inc;

  always_comb begin
    casez (byte_in[7:3])
      5'b0????: ones = 3'd0;
      5'b10???: ones = 3'd1;
      5'b110??: ones = 3'd2;
      5'b1110?: ones = 3'd3;
      5'b11110: ones = 3'd4;
      default:  ones = 3'd5;
    endcase
  end

  always_comb begin
    case (ones)
      3'd2:    lead_bits = {16'd0, byte_in[4:0]};
      3'd3:    lead_bits = {17'd0, byte_in[3:0]};
      3'd4:    lead_bits = {18'd0, byte_in[2:0]};
      default: lead_bits = '0;
    endcase
  end

  assign acc_shift = {st_r.acc[14:0], byte_in[5:0]};
  assign rem_dec   = st_r.rem - 2'd1;
  assign bad       = st_r.pend | (byte_in[7:6] != 2'b10);

  always_comb begin
    st_nxt    = st_r;
    em        = 1'b0;
    em_status = utf8d_pkg::STATUS_OK;
    em_cp     = '0;
    em_pos    = '0;
    em_len    = '0;

    if (st_r.disc) begin
      // drop until the end mark, which starts a new string
      if (eos) begin
        st_nxt = '0;
      end else begin
        st_nxt.offset = off_adv;
      end
    end else if (st_r.rem == 2'd0) begin
      if (ones == 3'd0) begin
        em    = 1'b1;
        em_cp = {13'd0, byte_in};
      end else if (ones == 3'd1 || ones == 3'd5) begin
        em        = 1'b1;
        em_status = utf8d_pkg::STATUS_BAD_LEAD;
        em_pos    = st_r.offset;
        em_len    = 3'd1;
      end else if (eos) begin
        em        = 1'b1;
        em_status = utf8d_pkg::STATUS_TRUNC;
        em_pos    = st_r.offset;
        em_len    = 3'd1;
      end else begin
        // open a multi-byte sequence
        st_nxt.seq_len = ones;
        st_nxt.rem     = 2'(ones - 3'd1);
        st_nxt.acc     = lead_bits;
        st_nxt.start   = st_r.offset;
        st_nxt.pend    = 1'b0;
        st_nxt.offset  = off_adv;
      end
    end else begin
      if (rem_dec == 2'd0) begin
        em = 1'b1;
        if (bad) begin
          em_status = utf8d_pkg::STATUS_BAD_FOLLOW;
          em_pos    = st_r.start;
          em_len    = st_r.seq_len;
        end else begin
          em_cp = acc_shift;
        end
      end else if (eos) begin
        em        = 1'b1;
        em_status = utf8d_pkg::STATUS_TRUNC;
        em_pos    = st_r.start;
        em_len    = 3'd1;
      end else begin
        st_nxt.acc    = acc_shift;
        st_nxt.rem    = rem_dec;
        st_nxt.pend   = bad;
        st_nxt.offset = off_adv;
      end
    end

    em_err = (em_status != utf8d_pkg::STATUS_OK);

    if (em) begin
      // a result closes the sequence; an error also ends the string
      st_nxt.rem     = '0;
      st_nxt.seq_len = '0;
      st_nxt.acc     = '0;
      st_nxt.start   = '0;
      st_nxt.pend    = 1'b0;
      if (eos) begin
        st_nxt.offset = '0;
        st_nxt.disc   = 1'b0;
      end else begin
        st_nxt.offset = off_adv;
        st_nxt.disc   = em_err;
      end
    end
  end

  assign res_valid          = em;
  assign res.code_point     = em_cp;
  assign res.status         = em_status;
  assign res.error_position = em_pos;
  assign res.error_length   = em_len;
  assign res.last_result    = eos | em_err;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (step_go) begin
      st_r <= st_nxt;
    end
  end

  a_disc_no_seq : assert property (@(posedge clk) disable iff (!rst_n)
    st_r.disc |-> st_r.rem == 2'd0)
    else $error("dropping with a sequence still open");

  a_pend_in_seq : assert property (@(posedge clk) disable iff (!rst_n)
    st_r.pend |-> st_r.rem != 2'd0)
    else $error("bad continuation flag outside a sequence");

  a_len_covers : assert property (@(posedge clk) disable iff (!rst_n)
    st_r.rem != 2'd0 |-> st_r.seq_len > {1'b0, st_r.rem})
    else $error("sequence length shorter than bytes expected");

  a_err_last : assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.status != utf8d_pkg::STATUS_OK |-> res.last_result)
    else $error("error result not marked last");

endmodule

### sv/utf8d_outbuf.sv
module utf8d_outbuf (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                load,
  input  utf8d_pkg::result_t                  res,
  output logic                                space,
  input  logic                                out_tready,
  output logic                                out_tvalid,
  output logic [utf8d_pkg::OutDataW-1:0]      out_tdata,
  output logic                                out_tlast
);

  logic               valid_r;
  utf8d_pkg::result_t data_r;

  assign space = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {6'd0, data_r.error_length, data_r.error_position,
                       data_r.status, data_r.code_point};
  assign out_tlast  = data_r.last_result;

endmodule
